[rtl/qte_pkg.sv]
// Shared types, constants and tables for the quaternion to Euler angle pipeline.
// Used by qte_cordic, qte_isqrt and quaternion_to_euler_angles. No dependencies.
package qte_pkg;

  localparam int ARCTAN_STAGES = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_N = (ARCTAN_STAGES < ATAN_TABLE_LEN) ? ARCTAN_STAGES : ATAN_TABLE_LEN;
  localparam int CORDIC_LAT = CORDIC_N + 2;

  localparam int CW = 38;
  localparam int AW = 34;
  localparam int RW = AW - 16;

  localparam int SQ_IN_W = 57;
  localparam int SQ_W = 58;
  localparam int SQ_STEPS = 29;

  localparam int PIPE_DEPTH = 33 + CORDIC_LAT;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic signed [RW-1:0] res_t;

  localparam acc_t ANG_90 = 34'sd589824000;
  localparam acc_t ACC_HALF = 34'sd32768;

  function automatic acc_t atan_step(input int i);
    acc_t v;
    v = '0;
    case (i)
      0: v = 34'sd294912000;
      1: v = 34'sd174096719;
      2: v = 34'sd91987925;
      3: v = 34'sd46694507;
      4: v = 34'sd23437865;
      5: v = 34'sd11730358;
      6: v = 34'sd5866610;
      7: v = 34'sd2933484;
      8: v = 34'sd1466764;
      9: v = 34'sd733385;
      10: v = 34'sd366693;
      11: v = 34'sd183346;
      12: v = 34'sd91673;
      13: v = 34'sd45837;
      14: v = 34'sd22918;
      15: v = 34'sd11459;
      16: v = 34'sd5730;
      17: v = 34'sd2865;
      18: v = 34'sd1432;
      19: v = 34'sd716;
      20: v = 34'sd358;
      21: v = 34'sd179;
      22: v = 34'sd90;
      23: v = 34'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/qte_cordic.sv]
// Pipelined vectoring arctangent: quadrant pre-rotation, one stage per
// iteration, then rounding to whole centidegrees. Depends on qte_pkg.
module qte_cordic (
  input  logic           clk,
  input  logic           en,
  input  qte_pkg::cw_t   y_i,
  input  qte_pkg::cw_t   x_i,
  output qte_pkg::res_t  res_o
);
  import qte_pkg::*;

  cw_t  x_r   [0:CORDIC_N];
  cw_t  y_r   [0:CORDIC_N];
  acc_t acc_r [0:CORDIC_N];
  logic zero_r [0:CORDIC_N];
  cw_t  x_nxt [1:CORDIC_N];
  cw_t  y_nxt [1:CORDIC_N];
  acc_t acc_nxt [1:CORDIC_N];
  res_t res_r;

  always_comb begin
    for (int i = 1; i <= CORDIC_N; i++) begin
      if (y_r[i-1] > 0) begin
        x_nxt[i] = x_r[i-1] + (y_r[i-1] >>> (i - 1));
        y_nxt[i] = y_r[i-1] - (x_r[i-1] >>> (i - 1));
        acc_nxt[i] = acc_r[i-1] + atan_step(i - 1);
      end else begin
        x_nxt[i] = x_r[i-1] - (y_r[i-1] >>> (i - 1));
        y_nxt[i] = y_r[i-1] + (x_r[i-1] >>> (i - 1));
        acc_nxt[i] = acc_r[i-1] - atan_step(i - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_i == '0) && (y_i == '0);
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_r[0] <= y_i;
          y_r[0] <= -x_i;
          acc_r[0] <= ANG_90;
        end else begin
          x_r[0] <= -y_i;
          y_r[0] <= x_i;
          acc_r[0] <= -ANG_90;
        end
      end else begin
        x_r[0] <= x_i;
        y_r[0] <= y_i;
        acc_r[0] <= '0;
      end
      for (int i = 1; i <= CORDIC_N; i++) begin
        x_r[i] <= x_nxt[i];
        y_r[i] <= y_nxt[i];
        acc_r[i] <= acc_nxt[i];
        zero_r[i] <= zero_r[i-1];
      end
      res_r <= zero_r[CORDIC_N] ? '0 : res_t'((acc_r[CORDIC_N] + ACC_HALF) >>> 16);
    end
  end

  assign res_o = res_r;

endmodule

[rtl/qte_isqrt.sv]
// Pipelined integer square root, one result bit per stage (floor).
// Depends on qte_pkg.
module qte_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qte_pkg::SQ_IN_W-1:0]   n_i,
  output logic [qte_pkg::SQ_STEPS-1:0]  r_o
);
  import qte_pkg::*;

  logic [SQ_W-1:0] n_r   [0:SQ_STEPS-1];
  logic [SQ_W-1:0] r_r   [0:SQ_STEPS-1];
  logic [SQ_W-1:0] n_nxt [0:SQ_STEPS-1];
  logic [SQ_W-1:0] r_nxt [0:SQ_STEPS-1];

  always_comb begin
    logic [SQ_W-1:0] nin;
    logic [SQ_W-1:0] rin;
    logic [SQ_W-1:0] b;
    logic [SQ_W-1:0] t;
    for (int k = 0; k < SQ_STEPS; k++) begin
      if (k == 0) begin
        nin = SQ_W'(n_i);
        rin = '0;
      end else begin
        nin = n_r[k-1];
        rin = r_r[k-1];
      end
      b = SQ_W'(1) << (SQ_IN_W - 1 - 2 * k);
      t = rin + b;
      if (nin >= t) begin
        n_nxt[k] = nin - t;
        r_nxt[k] = (rin >> 1) + b;
      end else begin
        n_nxt[k] = nin;
        r_nxt[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_STEPS; k++) begin
        n_r[k] <= n_nxt[k];
        r_r[k] <= r_nxt[k];
      end
    end
  end

  assign r_o = r_r[SQ_STEPS-1][SQ_STEPS-1:0];

endmodule

[rtl/quaternion_to_euler_angles.sv]
// Quaternion (Q1.14) to ZYX roll, pitch, yaw in centidegrees, fully pipelined.
// Depends on qte_pkg, qte_cordic, qte_isqrt.
//
//   channel  ports                                         dir
//   input    in_valid in_ready in_quat_w/x/y/z              in
//   result   out_valid out_ready out_roll/pitch/yaw_cdeg    out
//
// One item per cycle while the output is not stalled; the pitch path sets the depth:
// products, sums, square, 29 root stages, arctangent, output.
// Stall: the whole pipeline holds while the output register is full and not taken.
// Reset clears the valid bits only; no clearing pass.
module quaternion_to_euler_angles (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_roll_cdeg,
  output logic signed [14:0] out_pitch_cdeg,
  output logic signed [15:0] out_yaw_cdeg
);
  import qte_pkg::*;

  localparam int DLY = SQ_STEPS + 1;
  localparam int FLN = DLY + CORDIC_LAT + 1;

  logic adv;
  logic [PIPE_DEPTH-1:0] v_r;

  logic signed [31:0] p_wx_r, p_yz_r, p_wy_r, p_zx_r, p_wz_r, p_xy_r;
  logic signed [31:0] p_xx_r, p_yy_r, p_zz_r;
  logic signed [33:0] sr_r, cr_r, sp_r, sy_r, cy_r;
  logic signed [33:0] sr_nxt, cr_nxt, sp_nxt, sy_nxt, cy_nxt;
  logic signed [28:0] sp29;
  logic signed [57:0] sq_nxt;
  logic [SQ_IN_W-1:0] rem_r;
  logic signed [28:0] spc_r [0:DLY-1];
  logic [1:0] fl_r [0:FLN-1];
  logic [SQ_STEPS-1:0] root;
  res_t roll_res, yaw_res, pitch_res;
  res_t rd_r [0:DLY-1];
  res_t yd_r [0:DLY-1];
  logic signed [15:0] roll_r, yaw_r;
  logic signed [14:0] pitch_r;

  assign adv = !v_r[PIPE_DEPTH-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_comb begin
    sr_nxt = (34'(p_wx_r) + 34'(p_yz_r)) <<< 1;
    sp_nxt = (34'(p_wy_r) - 34'(p_zx_r)) <<< 1;
    sy_nxt = (34'(p_wz_r) + 34'(p_xy_r)) <<< 1;
    cr_nxt = (34'sd1 <<< 28) - ((34'(p_xx_r) + 34'(p_yy_r)) <<< 1);
    cy_nxt = (34'sd1 <<< 28) - ((34'(p_yy_r) + 34'(p_zz_r)) <<< 1);
    sp29 = sp_r[28:0];
    sq_nxt = sp29 * sp29;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx_r <= in_quat_w * in_quat_x;
      p_yz_r <= in_quat_y * in_quat_z;
      p_wy_r <= in_quat_w * in_quat_y;
      p_zx_r <= in_quat_z * in_quat_x;
      p_wz_r <= in_quat_w * in_quat_z;
      p_xy_r <= in_quat_x * in_quat_y;
      p_xx_r <= in_quat_x * in_quat_x;
      p_yy_r <= in_quat_y * in_quat_y;
      p_zz_r <= in_quat_z * in_quat_z;
      sr_r <= sr_nxt;
      cr_r <= cr_nxt;
      sp_r <= sp_nxt;
      sy_r <= sy_nxt;
      cy_r <= cy_nxt;
      fl_r[0] <= {sp_nxt >= (34'sd1 <<< 28), sp_nxt <= -(34'sd1 <<< 28)};
      for (int i = 1; i < FLN; i++) fl_r[i] <= fl_r[i-1];
      spc_r[0] <= sp29;
      for (int i = 1; i < DLY; i++) spc_r[i] <= spc_r[i-1];
      rem_r <= SQ_IN_W'((58'sd1 <<< 56) - sq_nxt);
      rd_r[0] <= roll_res;
      yd_r[0] <= yaw_res;
      for (int i = 1; i < DLY; i++) begin
        rd_r[i] <= rd_r[i-1];
        yd_r[i] <= yd_r[i-1];
      end
      if (rd_r[DLY-1] > 18000) roll_r <= 16'sd18000;
      else if (rd_r[DLY-1] < -18000) roll_r <= -16'sd18000;
      else roll_r <= rd_r[DLY-1][15:0];
      if (yd_r[DLY-1] > 18000) yaw_r <= 16'sd18000;
      else if (yd_r[DLY-1] < -18000) yaw_r <= -16'sd18000;
      else yaw_r <= yd_r[DLY-1][15:0];
      priority if (fl_r[FLN-1][1]) pitch_r <= 15'sd9000;
      else if (fl_r[FLN-1][0]) pitch_r <= -15'sd9000;
      else if (pitch_res > 9000) pitch_r <= 15'sd9000;
      else if (pitch_res < -9000) pitch_r <= -15'sd9000;
      else pitch_r <= pitch_res[14:0];
    end
  end

  qte_cordic u_roll (
    .clk(clk), .en(adv), .y_i(CW'(sr_r)), .x_i(CW'(cr_r)), .res_o(roll_res)
  );

  qte_cordic u_yaw (
    .clk(clk), .en(adv), .y_i(CW'(sy_r)), .x_i(CW'(cy_r)), .res_o(yaw_res)
  );

  qte_isqrt u_root (
    .clk(clk), .en(adv), .n_i(rem_r), .r_o(root)
  );

  qte_cordic u_pitch (
    .clk(clk), .en(adv), .y_i(CW'(spc_r[DLY-1])), .x_i(CW'({1'b0, root})),
    .res_o(pitch_res)
  );

  assign out_valid = v_r[PIPE_DEPTH-1];
  assign out_roll_cdeg = roll_r;
  assign out_pitch_cdeg = pitch_r;
  assign out_yaw_cdeg = yaw_r;

`ifndef SYNTHESIS
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_cdeg <= 9000 && out_pitch_cdeg >= -9000))
    else $error("pitch out of range");
  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_cdeg <= 18000 && out_roll_cdeg >= -18000))
    else $error("roll out of range");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_yaw_cdeg <= 18000 && out_yaw_cdeg >= -18000))
    else $error("yaw out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved during stall");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted item lost");
`endif

endmodule

[tb/sv/testbench.sv]
// Testbench for quaternion_to_euler_angles: directed and random quaternions,
// predicted angles checked field by field. Depends on qte_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import qte_pkg::*;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
  } euler_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1350;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_roll_cdeg, out_yaw_cdeg;
  logic signed [14:0] out_pitch_cdeg;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int idle_phase = 0;
  int stall_cycles = 0;
  bit stim_done = 1'b0;

  localparam longint ATAN_LUT[24] = '{
    294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183346,
    91673, 45837, 22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};

  always #5 clk = ~clk;

  quaternion_to_euler_angles u_top (.*);

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan2_cdeg(longint yv, longint xv, longint lim);
    longint acc, t, dx, dy, r;
    int n;
    acc = 0;
    n = (ARCTAN_STAGES < 24) ? ARCTAN_STAGES : 24;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        t = xv; xv = yv; yv = -t;
        acc = 589824000;
      end else begin
        t = xv; xv = -yv; yv = t;
        acc = -589824000;
      end
    end
    for (int i = 0; i < n; i++) begin
      dx = floor_shift(yv, i);
      dy = floor_shift(xv, i);
      if (yv > 0) begin
        xv = xv + dx; yv = yv - dy; acc += ATAN_LUT[i];
      end else begin
        xv = xv - dx; yv = yv + dy; acc -= ATAN_LUT[i];
      end
    end
    r = floor_shift(acc + 32768, 16);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic euler_t quat_to_euler(quat_t q);
    longint w, x, y, z, sr, cr, sp, sy, cy, p;
    longint one;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    one = 64'sd1 << 28;
    sr = 2 * (w * x + y * z);
    cr = one - 2 * (x * x + y * y);
    sp = 2 * (w * y - z * x);
    sy = 2 * (w * z + x * y);
    cy = one - 2 * (y * y + z * z);
    if (sp >= one) p = 9000;
    else if (sp <= -one) p = -9000;
    else p = atan2_cdeg(sp, root_floor((64'd1 << 56) - longint'(sp * sp)), 9000);
    e.roll = 16'(atan2_cdeg(sr, cr, 18000));
    e.pitch = 15'(p);
    e.yaw = 16'(atan2_cdeg(sy, cy, 18000));
    return e;
  endfunction

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'sd0;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // random quaternion: a normalized random rotation, or a quarter of the time raw random components
  function automatic quat_t rand_quat();
    quat_t q;
    real a, b, c, d, n;
    if ($urandom_range(0, 3) == 0) begin
      q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
    end else begin
      a = $urandom_range(0, 20000) - 10000.0;
      b = $urandom_range(0, 20000) - 10000.0;
      c = $urandom_range(0, 20000) - 10000.0;
      d = $urandom_range(0, 20000) - 10000.0;
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      q.w = 16'($rtoi(a / n * 16384.0));
      q.x = 16'($rtoi(b / n * 16384.0));
      q.y = 16'($rtoi(c / n * 16384.0));
      q.z = 16'($rtoi(d / n * 16384.0));
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d want %0d (item %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // pitch term just under +1/-1 and beyond, zero vectors, negative x axis, extremes
  initial begin
    quat_t q;
    int h;
    h = 11585;
    q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd0, 16'sd16384}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0}; pending_quats.push_back(q);
    q = '{16'(h), 16'sd0, 16'(h), 16'sd0}; pending_quats.push_back(q);
    q = '{16'(h), 16'sd0, -16'(h), 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0}; pending_quats.push_back(q);
    q = '{16'sd8192, 16'sd0, 16'sd8192, 16'sd0}; pending_quats.push_back(q);
    q = '{16'(h), 16'(h), 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{16'(h), 16'sd0, 16'sd0, -16'(h)}; pending_quats.push_back(q);
    q = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}; pending_quats.push_back(q);
    q = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}; pending_quats.push_back(q);
    q = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767}; pending_quats.push_back(q);
    q = '{16'sd0, 16'sd16384, 16'sd16384, 16'sd16384}; pending_quats.push_back(q);
    q = '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}; pending_quats.push_back(q);
    q = '{16'sd8192, -16'sd8192, -16'sd8192, -16'sd8192}; pending_quats.push_back(q);
    q = '{16'sd1, 16'sd0, 16'sd0, 16'sd0}; pending_quats.push_back(q);
    q = '{-16'sd1, -16'sd1, 16'sd1, -16'sd1}; pending_quats.push_back(q);
    for (int i = 0; i < N_RANDOM; i++) pending_quats.push_back(rand_quat());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic bit idles(bit sender);
    case (idle_phase)
      0: return $urandom_range(0, 99) < (sender ? 6 : 74);
      1: return $urandom_range(0, 99) < (sender ? 74 : 6);
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (n_sent >= 450 && idle_phase == 0) idle_phase <= 1;
      if (n_sent >= 900 && idle_phase == 1) idle_phase <= 2;
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          expected_angles.push_back(quat_to_euler({in_quat_w, in_quat_x, in_quat_y, in_quat_z}));
          n_sent <= n_sent + 1;
        end
        if (pending_quats.size() > 0 && !idles(1'b1)) begin
          quat_t q;
          q = pending_quats.pop_front();
          in_valid <= 1'b1;
          {in_quat_w, in_quat_x, in_quat_y, in_quat_z} <= q;
        end else begin
          in_valid <= 1'b0;
          if (pending_quats.size() == 0) stim_done <= 1'b1;
        end
      end
      out_ready <= !idles(1'b0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected result roll", out_roll_cdeg, 0);
        end else begin
          euler_t e;
          e = expected_angles.pop_front();
          if (out_roll_cdeg !== e.roll) report_mismatch("roll", out_roll_cdeg, e.roll);
          if (out_pitch_cdeg !== e.pitch) report_mismatch("pitch", out_pitch_cdeg, e.pitch);
          if (out_yaw_cdeg !== e.yaw) report_mismatch("yaw", out_yaw_cdeg, e.yaw);
        end
        n_checked++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (rst_n);
    while (!(stim_done && !in_valid && expected_angles.size() == 0)
           && stall_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      repeat (PIPE_DEPTH + 10) @(posedge clk);
      if (out_valid) begin
        report_mismatch("extra result roll", out_roll_cdeg, 0);
      end
      $display("Covered %0d quaternions: saturated pitch, zero vectors, axis cases,",
               n_checked);
      $display("unnormalized extremes and random rotations under three idling mixes.");
      if (n_errors == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
      $finish;
    end
  end
endmodule

[filelist.f]
rtl/qte_pkg.sv
rtl/qte_cordic.sv
rtl/qte_isqrt.sv
rtl/quaternion_to_euler_angles.sv
tb/sv/testbench.sv
